// File: design/kms_pkg.sv
// Shared types, constants and helper functions of the keyword marker scanner.
// Used by kms_ctrl, kms_dpath and keyword_marker_scanner_core; no dependencies.
package kms_pkg;

  // Buffer geometry
  localparam int BUFFER_BYTES = 64;
  localparam int ADDR_W       = $clog2(BUFFER_BYTES);
  localparam int LEN_W        = ADDR_W;
  localparam logic [LEN_W:0] LEN_LIMIT = (LEN_W + 1)'(BUFFER_BYTES - 2);

  // Keyword slots
  localparam int NUM_KW     = 8;
  localparam int KW_BYTES   = 8;
  localparam int KW_W       = 8 * KW_BYTES;
  localparam int KW_IDX_W   = $clog2(NUM_KW);
  localparam int POS_W      = $clog2(KW_BYTES + 1);
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = KW_W;

  // Byte codes
  localparam logic [7:0] DOLLAR  = 8'h24;
  localparam logic [7:0] COLON   = 8'h3A;
  localparam logic [7:0] NEWLINE = 8'h0A;
  localparam logic [7:0] NUL     = 8'h00;

  // Result kinds
  localparam logic KIND_RUN    = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Output word select
  localparam logic [1:0] OSEL_HEAD   = 2'd0;
  localparam logic [1:0] OSEL_BODY   = 2'd1;
  localparam logic [1:0] OSEL_TAIL   = 2'd2;
  localparam logic [1:0] OSEL_REPORT = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic              acc;        // input word taken this cycle
    logic              match_init; // reset per-slot compare flags
    logic              rd_en;      // read buffer at rd_addr
    logic [ADDR_W-1:0] rd_addr;
    logic              cmp;        // compare read byte at position pos
    logic [POS_W-1:0]  pos;
    logic              decide;     // resolve match result
    logic              out_ld;     // load output register
    logic [1:0]        out_sel;
    logic              file_end;   // clear per-file state
  } ctl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic             to_match;  // current input closes an open marker
    logic [LEN_W-1:0] len;
    logic             hit_any;
    logic             out_free;
  } dp_stat_t;

  // Keyword length: bytes up to the first zero, at most KW_BYTES
  function automatic logic [POS_W-1:0] kw_len(input logic [KW_W-1:0] kw);
    logic [POS_W-1:0] n;
    logic             run;
    n   = '0;
    run = 1'b1;
    for (int i = 0; i < KW_BYTES; i++) begin
      if (run && (kw[8*i +: 8] != NUL)) begin
        n = n + POS_W'(1);
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

  // Keyword byte at a position
  function automatic logic [7:0] kw_byte(input logic [KW_W-1:0] kw,
                                         input logic [KW_IDX_W-1:0] idx);
    return kw[8*idx +: 8];
  endfunction

endpackage

// File: design/kms_dpath.sv
// Datapath of the keyword marker scanner: keyword registers, marker buffer
// memory, per-slot match flags and the output register. Depends on kms_pkg.
module kms_dpath import kms_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           in_byte,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  ctl_cmd_t             cmd,
  output dp_stat_t             stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_kind,
  output logic [7:0]           out_byte,
  output logic                 out_last_of_run,
  output logic                 out_no_keywords
);

  logic [KW_W-1:0]   kw_r [NUM_KW];
  logic [7:0]        mem [BUFFER_BYTES];
  logic [7:0]        rd_data_r;

  logic              mode_r, mode_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              found_r, found_nxt;
  logic [NUM_KW-1:0] ok_r, ok_nxt;
  logic [NUM_KW-1:0] hit_r, hit_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r, out_last_r, out_nokw_r;
  logic [7:0]        out_byte_r;

  logic              is_dollar, is_nl, store_en;
  logic [LEN_W:0]    len_inc;

  assign is_dollar = (in_byte == DOLLAR);
  assign is_nl     = (in_byte == NEWLINE);
  assign store_en  = cmd.acc && mode_r && !is_dollar && !is_nl;
  assign len_inc   = {1'b0, len_r} + (LEN_W + 1)'(1);

  // Keyword registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_KW; s++) kw_r[s] <= '0;
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_KW))) begin
      kw_r[cfg_index[KW_IDX_W-1:0]] <= cfg_data;
    end
  end

  // Marker buffer: one write, one registered read
  always_ff @(posedge clk) begin
    if (store_en) begin
      mem[len_r] <= in_byte;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_addr];
    end
  end

  // Scan mode, length and found flag
  always_comb begin
    mode_nxt  = mode_r;
    len_nxt   = len_r;
    found_nxt = found_r;
    if (cmd.acc) begin
      if (!mode_r) begin
        if (is_dollar) begin
          mode_nxt = 1'b1;
          len_nxt  = '0;
        end
      end else if (is_nl) begin
        mode_nxt = 1'b0;
        len_nxt  = '0;
      end else if (!is_dollar) begin
        // store, then abandon when the buffer is nearly full
        if (len_inc >= LEN_LIMIT) begin
          mode_nxt = 1'b0;
          len_nxt  = '0;
        end else begin
          len_nxt = len_inc[LEN_W-1:0];
        end
      end
    end
    if (cmd.decide) begin
      if (stat.hit_any) begin
        found_nxt = 1'b1;
        mode_nxt  = 1'b0;
      end else begin
        len_nxt = '0;
      end
    end
    if (cmd.out_ld && (cmd.out_sel == OSEL_TAIL)) begin
      len_nxt = '0;
    end
    if (cmd.file_end) begin
      mode_nxt  = 1'b0;
      len_nxt   = '0;
      found_nxt = 1'b0;
    end
  end

  // Per-slot prefix and colon match, one buffer byte per compare
  always_comb begin
    logic [POS_W-1:0] n;
    ok_nxt  = ok_r;
    hit_nxt = hit_r;
    n       = '0;
    if (cmd.match_init) begin
      ok_nxt  = '1;
      hit_nxt = '0;
    end else if (cmd.cmp) begin
      for (int s = 0; s < NUM_KW; s++) begin
        n = kw_len(kw_r[s]);
        if (n != '0) begin
          if (cmd.pos < n) begin
            ok_nxt[s] = ok_r[s] && (rd_data_r == kw_byte(kw_r[s], cmd.pos[KW_IDX_W-1:0]));
          end else if (cmd.pos == n) begin
            hit_nxt[s] = ok_r[s] && (rd_data_r == COLON);
          end
        end
      end
    end
  end

  // Output register: hold while stalled, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      len_r       <= '0;
      found_r     <= 1'b0;
      ok_r        <= '0;
      hit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      len_r       <= len_nxt;
      found_r     <= found_nxt;
      ok_r        <= ok_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      unique case (cmd.out_sel)
        OSEL_HEAD: begin
          out_kind_r <= KIND_RUN;
          out_byte_r <= DOLLAR;
          out_last_r <= 1'b0;
          out_nokw_r <= 1'b0;
        end
        OSEL_BODY: begin
          out_kind_r <= KIND_RUN;
          out_byte_r <= rd_data_r;
          out_last_r <= 1'b0;
          out_nokw_r <= 1'b0;
        end
        OSEL_TAIL: begin
          out_kind_r <= KIND_RUN;
          out_byte_r <= DOLLAR;
          out_last_r <= 1'b1;
          out_nokw_r <= 1'b0;
        end
        OSEL_REPORT: begin
          out_kind_r <= KIND_REPORT;
          out_byte_r <= NUL;
          out_last_r <= 1'b1;
          out_nokw_r <= !found_r;
        end
        default: begin
          out_kind_r <= KIND_RUN;
          out_byte_r <= NUL;
          out_last_r <= 1'b0;
          out_nokw_r <= 1'b0;
        end
      endcase
    end
  end

  assign stat.to_match = mode_r && is_dollar;
  assign stat.len      = len_r;
  assign stat.hit_any  = |hit_r;
  assign stat.out_free = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;
  assign out_no_keywords = out_nokw_r;

  // A stored byte always lands below the abandon limit
  a_store_limit: assert property (@(posedge clk) disable iff (!rst_n)
    store_en |-> ({1'b0, len_r} < LEN_LIMIT))
    else $error("buffer write at or past the length limit");

  // End of file leaves the per-file state cleared
  a_file_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.file_end |=> (!mode_r && (len_r == '0) && !found_r))
    else $error("per-file state not cleared after report");

  // Found flag rises only on a resolved match
  a_found_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(found_r) |-> $past(cmd.decide && stat.hit_any))
    else $error("found flag set without a keyword match");

endmodule

// File: design/kms_ctrl.sv
// Controller of the keyword marker scanner: sequences input acceptance,
// buffer compare, marker run output and end-of-file report. Depends on kms_pkg.
module kms_ctrl import kms_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_end_of_file,
  output logic     in_stall,
  output ctl_cmd_t cmd,
  input  dp_stat_t stat
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MRD    = 4'd1;
  localparam logic [3:0] S_MCMP   = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_EHEAD  = 4'd4;
  localparam logic [3:0] S_ERD    = 4'd5;
  localparam logic [3:0] S_EOUT   = 4'd6;
  localparam logic [3:0] S_ETAIL  = 4'd7;
  localparam logic [3:0] S_REPORT = 4'd8;

  localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(KW_BYTES);

  logic [3:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic              eof_r, eof_nxt;
  logic              idx_at_end;

  assign in_stall   = (state_r != S_IDLE);
  assign idx_at_end = ((idx_r + ADDR_W'(1)) == stat.len);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    eof_nxt   = eof_r;
    cmd       = '0;
    cmd.rd_addr = idx_r;
    cmd.pos     = idx_r[POS_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.acc = 1'b1;
          eof_nxt = in_end_of_file;
          if (stat.to_match) begin
            cmd.match_init = 1'b1;
            idx_nxt        = '0;
            state_nxt      = (stat.len == '0) ? S_DECIDE : S_MRD;
          end else if (in_end_of_file) begin
            state_nxt = S_REPORT;
          end
        end
      end
      S_MRD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_MCMP;
      end
      S_MCMP: begin
        cmd.cmp = 1'b1;
        if ((idx_r == LAST_POS) || idx_at_end) begin
          state_nxt = S_DECIDE;
        end else begin
          idx_nxt   = idx_r + ADDR_W'(1);
          state_nxt = S_MRD;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (stat.hit_any) begin
          state_nxt = S_EHEAD;
        end else begin
          state_nxt = eof_r ? S_REPORT : S_IDLE;
        end
      end
      S_EHEAD: begin
        if (stat.out_free) begin
          cmd.out_ld  = 1'b1;
          cmd.out_sel = OSEL_HEAD;
          idx_nxt     = '0;
          state_nxt   = (stat.len == '0) ? S_ETAIL : S_ERD;
        end
      end
      S_ERD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_EOUT;
      end
      S_EOUT: begin
        if (stat.out_free) begin
          cmd.out_ld  = 1'b1;
          cmd.out_sel = OSEL_BODY;
          if (idx_at_end) begin
            state_nxt = S_ETAIL;
          end else begin
            idx_nxt   = idx_r + ADDR_W'(1);
            state_nxt = S_ERD;
          end
        end
      end
      S_ETAIL: begin
        if (stat.out_free) begin
          cmd.out_ld  = 1'b1;
          cmd.out_sel = OSEL_TAIL;
          state_nxt   = eof_r ? S_REPORT : S_IDLE;
        end
      end
      S_REPORT: begin
        if (stat.out_free) begin
          cmd.out_ld   = 1'b1;
          cmd.out_sel  = OSEL_REPORT;
          cmd.file_end = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      eof_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      eof_r   <= eof_nxt;
    end
  end

  // Output loads only into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> stat.out_free)
    else $error("output register overwritten while held");

  // Compare never runs past the colon after the longest keyword
  a_cmp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MCMP) |-> ((idx_r <= LAST_POS) && (idx_r < stat.len)))
    else $error("compare position out of range");

endmodule

// File: design/keyword_marker_scanner_core.sv
// Top level of the keyword marker scanner: joins controller and datapath.
// Depends on kms_pkg, kms_ctrl and kms_dpath.
//
//   channel | direction | handshake                | payload
//   in_     | input     | in_valid / in_stall      | in_byte, in_end_of_file
//   out_    | output    | out_valid / out_stall    | out_kind, out_byte,
//           |           |                          | out_last_of_run, out_no_keywords
//   cfg_    | input     | cfg_we                   | cfg_index, cfg_data
//
// Ordinary bytes are taken one per cycle while in_stall is low. A closing '$'
// holds the input while up to 9 buffer bytes are read and compared and the
// match is resolved. A matched run is a head '$', each buffered byte read via
// the single buffer read port, and a tail '$'; output stalls stretch it further.
// Reset is synchronous and active low; keyword registers clear to zero.
module keyword_marker_scanner_core import kms_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_byte,
  input  logic                  in_end_of_file,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_kind,
  output logic [7:0]            out_byte,
  output logic                  out_last_of_run,
  output logic                  out_no_keywords,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  kms_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_end_of_file (in_end_of_file),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .stat           (stat)
  );

  kms_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_byte         (in_byte),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_no_keywords (out_no_keywords)
  );

endmodule
